/* rtl/core/iterated_box_filter_line_top_assert.svh */
// Assertion macros for the iterated box filter line block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ITERATED_BOX_FILTER_LINE_TOP_ASSERT_SVH
`define ITERATED_BOX_FILTER_LINE_TOP_ASSERT_SVH

// Condition must never hold at a clock edge.
`define IBFL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ibfl assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define IBFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibfl assertion failed");

`endif

/* rtl/core/ibfl_pkg.sv */
// Shared types and constants of the iterated box filter line block.
// Used by every module of the block; depends on nothing.
package ibfl_pkg;

    localparam int LINE_MAX  = 64;
    localparam int ADDR_W    = 6;
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 28;
    localparam int RING_MAX  = 63;
    localparam int SUM_W     = 36;
    localparam int DVD_W     = 41;
    localparam int DEN_W     = 15;
    localparam int QUO_W     = 26;
    localparam int QCNT_W    = 5;
    localparam int BOX_W     = 14;

    localparam logic [1:0] CFG_BOX_WIDTH = 2'd0;
    localparam logic [1:0] CFG_PASSES    = 2'd1;
    localparam logic [1:0] CFG_DERIV     = 2'd2;
    localparam logic [1:0] CFG_EDGE      = 2'd3;

    localparam logic [1:0] DERIV_FIRST  = 2'd1;
    localparam logic [1:0] DERIV_SECOND = 2'd2;

    localparam logic [BOX_W-1:0] UNIT_WIDTH = 14'd256;

    typedef struct packed {
        logic [BOX_W-1:0] box_width;
        logic [1:0]       passes;
        logic [1:0]       deriv_order;
        logic             edge_mode;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [DATA_W-1:0] value;
    } line_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EDGE_LO,
        ST_EDGE_HI,
        ST_SETUP,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_NEXT_RD,
        ST_NEXT_WR,
        ST_SM_MUL,
        ST_SM_SUM,
        ST_SM_DIV,
        ST_DF_RD,
        ST_DF_WR,
        ST_EM_RD,
        ST_EM_WAIT,
        ST_EM_OUT
    } seq_state_t;

endpackage

/* rtl/core/iterated_box_filter_line_top.sv */
// Top level of the iterated box filter line block: configuration registers,
// output rounding and the output register. Depends on ibfl_pkg and ibfl_core.
//
// The block takes one line of up to 64 signed samples, one request per cycle,
// until a request with tlast set arrives; while the line is processed the input
// is not ready. With box_width above 1.0 and passes nonzero it runs that many
// in-place box passes of fractional width, then an optional first or second
// central difference, and finally returns the whole line with tlast on its
// final sample. Every smoothed sample is normalized by a shared restoring
// divider that produces one quotient bit per cycle, so a box pass waits on the
// divider for every sample after it has set up its window; a difference pass
// reads and writes each sample in turn, and readout waits on the receiver for
// each sample. Samples beyond 64 in a line are dropped. Configuration
// must only be written while no line is being loaded or processed.
module iterated_box_filter_line_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample_out
    output logic        m_tlast
);
    import ibfl_pkg::*;

    `include "iterated_box_filter_line_top_assert.svh"

    cfg_t      cfg_reg, cfg_next;
    line_out_t core_out;
    logic      core_ready;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              neg;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] rnd;
    logic [19:0]       q;
    logic [15:0]       sat;

    // Register writes; indexes are the package codes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOX_WIDTH: cfg_next.box_width   = cfg_data;
                CFG_PASSES:    cfg_next.passes      = cfg_data[1:0];
                CFG_DERIV:     cfg_next.deriv_order = cfg_data[1:0];
                CFG_EDGE:      cfg_next.edge_mode   = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_width   <= '0;
            cfg_reg.passes      <= 2'd1;
            cfg_reg.deriv_order <= '0;
            cfg_reg.edge_mode   <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    ibfl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .line_out  (core_out),
        .out_ready (core_ready)
    );

    // The stored value has 8 fractional bits: round to nearest with ties away
    // from zero on the magnitude, then saturate to the signed 16-bit range.
    always_comb
    begin
        neg = core_out.value[DATA_W-1];
        mag = neg ? DATA_W'(-core_out.value) : DATA_W'(core_out.value);
        rnd = mag + DATA_W'(128);
        q   = rnd[DATA_W-1:8];
        if (!neg && q > 20'd32767)
            sat = 16'h7FFF;
        else if (neg && q > 20'd32768)
            sat = 16'h8000;
        else if (neg)
            sat = 16'(-q);
        else
            sat = q[15:0];
    end

    // The output register lets the core present the next sample while the
    // current one waits for the downstream side.
    assign core_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (core_ready)
        begin
            m_tvalid_next = core_out.valid;
            m_tdata_next  = sat;
            m_tlast_next  = core_out.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `IBFL_ASSERT_NEVER(a_load_vs_emit, s_tready && core_out.valid)
    `IBFL_ASSERT_NEXT(a_last_closes_input, s_tvalid && s_tready && s_tlast, !s_tready)
    `IBFL_ASSERT_NEXT(a_passes_write, cfg_we && cfg_index == CFG_PASSES, cfg_reg.passes == $past(cfg_data[1:0]))

endmodule

/* rtl/core/ibfl_div.sv */
// Restoring divider, one quotient bit per cycle, for the box filter normalization.
// Depends on ibfl_pkg.
module ibfl_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ibfl_pkg::DVD_W-1:0]  dividend,
    input  logic [ibfl_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [ibfl_pkg::QUO_W-1:0]  quotient
);
    import ibfl_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[QUO_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[DVD_W-1:QUO_W];
            dvd_next  = dividend[QUO_W-1:0];
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            dvd_next = {dvd_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/ibfl_core.sv */
// Line store, window ring and the sequencer that loads, smooths, differences
// and reads out one line. Depends on ibfl_pkg and ibfl_div.
module ibfl_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ibfl_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [15:0]             in_sample,
    input  logic                           in_last,
    output ibfl_pkg::line_out_t            line_out,
    input  logic                           out_ready
);
    import ibfl_pkg::*;

    logic signed [DATA_W-1:0] store_mem [LINE_MAX];
    logic signed [DATA_W-1:0] ring_mem  [RING_MAX];
    logic signed [DATA_W-1:0] store_rdata_reg, ring_rdata_reg;

    seq_state_t state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  x_reg, x_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [1:0]        pass_reg, pass_next;
    logic              diff_reg, diff_next;
    logic              neg_reg, neg_next;
    logic              oor_lo_reg, oor_hi_reg;
    logic signed [DATA_W-1:0] edge_lo_reg, edge_lo_next, edge_hi_reg, edge_hi_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next, next_reg, next_nx;
    logic signed [DATA_W-1:0] p_reg, p_next, c_reg, c_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [38:0]       prod_reg, prod_next;
    line_out_t                out_reg, out_next;

    logic [4:0]        w2;
    logic [ADDR_W-1:0] win;
    logic [8:0]        fnum;
    logic              smooth_on, deriv_on;
    logic signed [8:0] pos;
    logic              pos_lo, pos_hi;
    logic signed [DATA_W-1:0] tap_val, edge_lo_tap;
    logic [BOX_W-1:0]  wm;
    logic [13:0]       win_w;

    logic               st_we;
    logic [ADDR_W-1:0]  st_waddr, st_raddr;
    logic signed [DATA_W-1:0] st_wdata;
    logic               rg_we;
    logic [ADDR_W-1:0]  rg_addr;
    logic signed [DATA_W-1:0] rg_wdata;

    logic signed [28:0] pn;
    logic signed [44:0] sum_sh;
    logic signed [41:0] num;
    logic [41:0]        mag;
    logic [DVD_W-1:0]   dvd;
    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_q;
    logic [DATA_W-1:0]  q_ext;
    logic signed [28:0] d1;
    logic [28:0]        m1;
    logic [28:0]        h1;
    logic signed [29:0] d2;
    logic signed [DATA_W-1:0] df_res;

    ibfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  ({cfg.box_width, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        wm        = cfg.box_width - UNIT_WIDTH;
        w2        = wm[13:9];
        win       = {w2, 1'b1};
        win_w     = {win, 8'b0};
        fnum      = 9'(cfg.box_width - win_w);
        smooth_on = (cfg.box_width > UNIT_WIDTH) && (cfg.passes != 2'd0);
        deriv_on  = (cfg.deriv_order == DERIV_FIRST) || (cfg.deriv_order == DERIV_SECOND);
        edge_lo_tap = cfg.edge_mode ? edge_lo_reg : '0;
        tap_val = oor_lo_reg ? edge_lo_tap :
                  oor_hi_reg ? (cfg.edge_mode ? edge_hi_reg : '0) : store_rdata_reg;

        unique case (state_reg)
            ST_INIT_RD: pos = $signed({3'b0, k_reg}) - $signed({4'b0, w2});
            ST_NEXT_RD: pos = $signed({4'b0, w2}) + 9'sd1;
            ST_SM_MUL:  pos = $signed({2'b0, x_reg}) + $signed({4'b0, w2}) + 9'sd2;
            ST_DF_RD:   pos = $signed({2'b0, x_reg}) + 9'sd1;
            default:    pos = '0;
        endcase
        pos_lo = pos < 0;
        pos_hi = pos >= $signed({2'b0, n_reg});

        pn     = $signed({prev_reg[DATA_W-1], prev_reg}) + $signed({next_reg[DATA_W-1], next_reg});
        sum_sh = {sum_reg, 9'b0};
        num    = sum_sh[41:0] + {{3{prod_reg[38]}}, prod_reg};
        mag    = num[41] ? 42'(-num) : 42'(num);
        dvd    = mag[DVD_W-1:0] + {27'b0, cfg.box_width};
        q_ext  = {2'b0, div_q};

        d1     = $signed({tap_val[DATA_W-1], tap_val}) - $signed({p_reg[DATA_W-1], p_reg});
        m1     = d1[28] ? 29'(-d1) : 29'(d1);
        h1     = (m1 + 29'd1) >> 1;
        d2     = $signed({{2{tap_val[DATA_W-1]}}, tap_val})
               - $signed({c_reg[DATA_W-1], c_reg, 1'b0})
               + $signed({{2{p_reg[DATA_W-1]}}, p_reg});
        if (cfg.deriv_order == DERIV_FIRST)
            df_res = d1[28] ? DATA_W'(-h1) : DATA_W'(h1);
        else
            df_res = d2[DATA_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        n_next       = n_reg;
        x_next       = x_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        pass_next    = pass_reg;
        diff_next    = diff_reg;
        neg_next     = neg_reg;
        edge_lo_next = edge_lo_reg;
        edge_hi_next = edge_hi_reg;
        prev_next    = prev_reg;
        next_nx      = next_reg;
        p_next       = p_reg;
        c_next       = c_reg;
        sum_next     = sum_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        in_ready     = 1'b0;
        st_we        = 1'b0;
        st_waddr     = x_reg[ADDR_W-1:0];
        st_wdata     = '0;
        st_raddr     = pos[ADDR_W-1:0];
        rg_we        = 1'b0;
        rg_addr      = head_reg;
        rg_wdata     = next_reg;
        div_start    = 1'b0;
        out_next.valid = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (len_reg < LEN_W'(LINE_MAX))
                    begin
                        st_we    = 1'b1;
                        st_waddr = len_reg[ADDR_W-1:0];
                        st_wdata = {{(DATA_W-24){in_sample[15]}}, in_sample, 8'b0};
                        len_next = len_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        n_next    = len_next;
                        pass_next = '0;
                        x_next    = '0;
                        if (smooth_on)
                        begin
                            diff_next  = 1'b0;
                            state_next = ST_EDGE_LO;
                        end
                        else if (deriv_on)
                        begin
                            diff_next  = 1'b1;
                            state_next = ST_EDGE_LO;
                        end
                        else
                            state_next = ST_EM_RD;
                    end
                end
            end
            ST_EDGE_LO:
            begin
                st_raddr   = '0;
                state_next = ST_EDGE_HI;
            end
            ST_EDGE_HI:
            begin
                st_raddr     = ADDR_W'(n_reg - 1'b1);
                edge_lo_next = store_rdata_reg;
                state_next   = ST_SETUP;
            end
            ST_SETUP:
            begin
                edge_hi_next = store_rdata_reg;
                x_next       = '0;
                k_next       = '0;
                sum_next     = '0;
                p_next       = edge_lo_tap;
                c_next       = edge_lo_reg;
                state_next   = diff_reg ? ST_DF_RD : ST_INIT_RD;
            end
            ST_INIT_RD:
                state_next = ST_INIT_WR;
            ST_INIT_WR:
            begin
                rg_we    = 1'b1;
                rg_addr  = k_reg;
                rg_wdata = tap_val;
                sum_next = sum_reg + SUM_W'(tap_val);
                k_next   = k_reg + 1'b1;
                state_next = (k_reg == win - 1'b1) ? ST_NEXT_RD : ST_INIT_RD;
            end
            ST_NEXT_RD:
            begin
                prev_next  = edge_lo_tap;
                state_next = ST_NEXT_WR;
            end
            ST_NEXT_WR:
            begin
                next_nx    = tap_val;
                head_next  = '0;
                state_next = ST_SM_MUL;
            end
            ST_SM_MUL:
            begin
                prod_next  = $signed({1'b0, fnum}) * pn;
                state_next = ST_SM_SUM;
            end
            ST_SM_SUM:
            begin
                div_start = 1'b1;
                neg_next  = num[41];
                prev_next = ring_rdata_reg;
                sum_next  = sum_reg + SUM_W'(next_reg) - SUM_W'(ring_rdata_reg);
                rg_we     = 1'b1;
                next_nx   = tap_val;
                head_next = (head_reg == win - 1'b1) ? '0 : head_reg + 1'b1;
                state_next = ST_SM_DIV;
            end
            ST_SM_DIV:
            begin
                if (div_done)
                begin
                    st_we    = 1'b1;
                    st_wdata = neg_reg ? DATA_W'(-q_ext) : DATA_W'(q_ext);
                    x_next   = x_reg + 1'b1;
                    if (x_reg == n_reg - 1'b1)
                    begin
                        pass_next = pass_reg + 1'b1;
                        x_next    = '0;
                        if (pass_reg + 2'd1 != cfg.passes)
                            state_next = ST_EDGE_LO;
                        else if (deriv_on)
                        begin
                            diff_next  = 1'b1;
                            state_next = ST_EDGE_LO;
                        end
                        else
                            state_next = ST_EM_RD;
                    end
                    else
                        state_next = ST_SM_MUL;
                end
            end
            ST_DF_RD:
                state_next = ST_DF_WR;
            ST_DF_WR:
            begin
                st_we    = 1'b1;
                st_wdata = df_res;
                p_next   = c_reg;
                c_next   = tap_val;
                x_next   = x_reg + 1'b1;
                if (x_reg == n_reg - 1'b1)
                begin
                    x_next     = '0;
                    state_next = ST_EM_RD;
                end
                else
                    state_next = ST_DF_RD;
            end
            ST_EM_RD:
            begin
                st_raddr   = x_reg[ADDR_W-1:0];
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                out_next.value = store_rdata_reg;
                out_next.last  = (x_reg == n_reg - 1'b1);
                out_next.valid = 1'b1;
                state_next     = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                out_next.valid = 1'b1;
                if (out_ready)
                begin
                    out_next.valid = 1'b0;
                    if (out_reg.last)
                    begin
                        len_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            len_reg   <= '0;
            pass_reg  <= '0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pass_reg  <= pass_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        x_reg       <= x_next;
        k_reg       <= k_next;
        head_reg    <= head_next;
        diff_reg    <= diff_next;
        neg_reg     <= neg_next;
        oor_lo_reg  <= pos_lo;
        oor_hi_reg  <= pos_hi;
        edge_lo_reg <= edge_lo_next;
        edge_hi_reg <= edge_hi_next;
        prev_reg    <= prev_next;
        next_reg    <= next_nx;
        p_reg       <= p_next;
        c_reg       <= c_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        store_rdata_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rg_we)
            ring_mem[rg_addr] <= rg_wdata;
        ring_rdata_reg <= ring_mem[rg_addr];
    end

    assign line_out = out_reg;

endmodule

/* tb/ibfl_line_checker.sv */
// Checker for the iterated box filter line block: watches the configuration
// port and both streams, predicts every filtered line, and compares results.
// Depends on ibfl_pkg for the configuration register indexes.
`timescale 1ns / 100ps

module ibfl_line_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          lines_pending
);
    import ibfl_pkg::*;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } filtered_t;

    filtered_t   filtered_q[$];
    logic [13:0] box_width;
    logic [1:0]  passes;
    logic [1:0]  deriv_order;
    logic        edge_mode;
    int          line_len;
    longint      line_buf[LINE_MAX];
    longint      src_buf[LINE_MAX];
    longint      ring_buf[RING_MAX];

    // Rounds to nearest, ties away from zero.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint tap_at(int pos, int n);
        if (pos < 0)
            return edge_mode ? src_buf[0] : 0;
        if (pos >= n)
            return edge_mode ? src_buf[n - 1] : 0;
        return src_buf[pos];
    endfunction

    task automatic box_pass(int n);
        longint w, w2, win, fnum, den, run_sum, prev, nxt;
        int head;
        w = box_width;
        w2 = (w - 256) / 512;
        if (w2 > (RING_MAX - 1) / 2)
            w2 = (RING_MAX - 1) / 2;
        win = 2 * w2 + 1;
        fnum = w - win * 256;
        den = 2 * w;
        for (int k = 0; k < n; k++)
            src_buf[k] = line_buf[k];
        run_sum = 0;
        for (int k = 0; k < win; k++)
        begin
            ring_buf[k] = tap_at(k - int'(w2), n);
            run_sum += ring_buf[k];
        end
        head = 0;
        prev = tap_at(-int'(w2) - 1, n);
        nxt = tap_at(int'(w2) + 1, n);
        for (int x = 0; x < n; x++)
        begin
            line_buf[x] = longint'(int'(round_div(512 * run_sum + fnum * (prev + nxt), den)));
            prev = ring_buf[head];
            run_sum -= prev;
            ring_buf[head] = nxt;
            run_sum += nxt;
            head = (head + 1 < win) ? head + 1 : 0;
            nxt = tap_at(x + int'(w2) + 2, n);
        end
    endtask

    task automatic filter_line(int n);
        longint r;
        filtered_t item;
        if (box_width > UNIT_WIDTH)
            for (int p = 0; p < passes; p++)
                box_pass(n);
        if (deriv_order == DERIV_FIRST || deriv_order == DERIV_SECOND)
        begin
            for (int k = 0; k < n; k++)
                src_buf[k] = line_buf[k];
            for (int x = 0; x < n; x++)
                if (deriv_order == DERIV_FIRST)
                    line_buf[x] = round_div(tap_at(x + 1, n) - tap_at(x - 1, n), 2);
                else
                    line_buf[x] = tap_at(x + 1, n) - 2 * tap_at(x, n) + tap_at(x - 1, n);
        end
        for (int x = 0; x < n; x++)
        begin
            r = round_div(line_buf[x], 256);
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            item.sample = r[15:0];
            item.last = (x == n - 1);
            filtered_q.push_back(item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            box_width = 14'd0;
            passes = 2'd1;
            deriv_order = 2'd0;
            edge_mode = 1'b1;
            line_len = 0;
            fail_count = 0;
            filtered_q.delete();
            lines_pending = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_BOX_WIDTH: box_width = cfg_data;
                    CFG_PASSES:    passes = cfg_data[1:0];
                    CFG_DERIV:     deriv_order = cfg_data[1:0];
                    CFG_EDGE:      edge_mode = cfg_data[0];
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected result: sample_out %0d", $signed(m_tdata));
                    fail_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $error("sample_out expected %0d actual %0d",
                               $signed(want.sample), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_out expected %0b actual %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                // Samples past a full line store are dropped.
                if (line_len < LINE_MAX)
                begin
                    line_buf[line_len] = longint'($signed(s_tdata)) * 256;
                    line_len++;
                end
                if (s_tlast)
                begin
                    filter_line(line_len);
                    line_len = 0;
                end
            end
            lines_pending = filtered_q.size();
        end
    end

endmodule

/* tb/tb_iterated_box_filter_line_top.sv */
// Testbench top for the iterated box filter line block: clock, reset, request
// stimulus, random backpressure and the verdict. Depends on ibfl_pkg,
// iterated_box_filter_line_top and ibfl_line_checker.
`timescale 1ns / 100ps

module tb_iterated_box_filter_line_top;
    import ibfl_pkg::*;

    localparam int IDLE_LIMIT = 60000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_BOX_WIDTH;
    logic [13:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [15:0] sample_in
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample_out
    logic        m_tlast;

    int fail_count;
    int lines_pending;
    int samples_sent = 0;
    int lines_sent = 0;
    int results_taken = 0;
    int idle_cycles = 0;
    bit sender_quiet = 0;

    always #5 clk = ~clk;

    iterated_box_filter_line_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    ibfl_line_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .lines_pending(lines_pending)
    );

    // The watchdog only looks at handshakes. A full 64-sample line with three
    // wide passes keeps the block busy without any handshake, so the limit
    // sits well above that time plus the long receiver hold.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: a random stall before every result, quiet stretches with no
    // stall at all, and one long hold early on. During that hold the sender
    // keeps offering the next line, so the block backs up into its input.
    initial
    begin
        int gap;
        bit quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            if (results_taken % 20 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (results_taken == 1)
                gap = 600;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            results_taken++;
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_sample(logic [15:0] value, logic last);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        samples_sent++;
        if (last)
            lines_sent++;
    endtask

    task automatic send_line(int len, bit extreme);
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            v = 16'($urandom);
            if (extreme)
                v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            send_sample(v, i == len - 1);
        end
    endtask

    // The sender pauses until every expected result has come, then waits for
    // the block to settle before any register write.
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (lines_pending != 0);
        repeat (10) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges.
    task automatic write_config(logic [13:0] width, logic [1:0] npass,
                                logic [1:0] order, logic edge_sel);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BOX_WIDTH;
        cfg_data <= width;
        @(posedge clk);
        cfg_index <= CFG_PASSES;
        cfg_data <= {12'd0, npass};
        @(posedge clk);
        cfg_index <= CFG_DERIV;
        cfg_data <= {12'd0, order};
        @(posedge clk);
        cfg_index <= CFG_EDGE;
        cfg_data <= {13'd0, edge_sel};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config;
        logic [13:0] width;
        case ($urandom_range(0, 5))
            0: width = 14'd0;
            1: width = UNIT_WIDTH;
            2: width = UNIT_WIDTH + 14'd1;
            3: width = 14'h3fff;
            4: width = 14'($urandom_range(257, 2500));
            default: width = 14'($urandom);
        endcase
        write_config(width, 2'($urandom), 2'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration: both extremes,
        // a one-sample line and a short mixed line.
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b1);
        send_line(1, 1);
        drain();
        // Widest window (the half width reaches its maximum), zero edges, first difference.
        write_config(14'h3fff, 2'd3, DERIV_FIRST, 1'b0);
        send_line(6, 1);
        drain();
        // Width just above one, second difference, nearest-edge samples.
        write_config(UNIT_WIDTH + 14'd1, 2'd2, DERIV_SECOND, 1'b1);
        send_line(5, 1);
        drain();
        // Width of exactly one gives no smoothing; order 3 behaves as none.
        write_config(UNIT_WIDTH, 2'd1, 2'd3, 1'b0);
        send_line(4, 0);
        drain();
        // No passes at a wide width, first difference on a one-sample line.
        write_config(14'd1000, 2'd0, DERIV_FIRST, 1'b1);
        send_line(1, 1);
        drain();

        // Random part: a new configuration every few lines, mostly short
        // lines, a few full ones and at times lines that overflow the line store.
        while (samples_sent < 310)
        begin
            random_config();
            sender_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(30, 64);
                    1: len = (lines_sent % 4 == 0) ? 70 : 64;
                    default: len = $urandom_range(1, 10);
                endcase
                send_line(len, $urandom_range(0, 7) == 0);
            end
            drain();
        end
        sender_quiet = 0;

        $display("Covered %0d requests in %0d lines and %0d results", samples_sent,
                 lines_sent, results_taken);
        $display("over random widths, pass counts, difference orders and edge modes.");
        if (fail_count == 0 && lines_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
